// File: src/rau_pkg.sv
// Package: shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned MagWidth     = 2 * OperandWidth + 1;
  localparam int unsigned CntWidth     = $clog2(MagWidth + 1);
  localparam int unsigned NumWidth     = 33;
  localparam int unsigned DenWidth     = 31;

  typedef logic [MagWidth-1:0] mag_t;

  typedef enum logic [2:0] {
    ActAdd = 3'd0,
    ActSub = 3'd1,
    ActMul = 3'd2,
    ActDiv = 3'd3,
    ActCmp = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    OrdLess    = 2'd0,
    OrdEqual   = 2'd1,
    OrdGreater = 2'd2
  } order_e;

  // Bit handed from one divider cell to the next.
  typedef struct packed {
    logic vld;
    logic bit_v;
  } qbit_t;

endpackage

// File: src/rau_cell.sv
// One divider cell: holds one quotient bit, shifts it to its neighbor each cycle.
module rau_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  rau_pkg::qbit_t prev_i,
  output rau_pkg::qbit_t cell_o
);
  import rau_pkg::*;

  qbit_t cell_q, cell_d;

  always_comb begin
    cell_d = prev_i;
    if (clr_i) begin
      cell_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

// File: src/rau_qchain.sv
// Quotient chain: a row of cells collecting quotient bits, MSB first.
module rau_qchain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clr_i,
  input  rau_pkg::qbit_t in_i,
  output rau_pkg::mag_t  quot_o
);
  import rau_pkg::*;

  qbit_t chain [MagWidth+1];

  assign chain[0] = in_i;

  for (genvar i = 0; i < MagWidth; i++) begin : g_cell
    rau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (clr_i),
      .prev_i (chain[i]),
      .cell_o (chain[i+1])
    );
    assign quot_o[MagWidth-1-i] = chain[MagWidth-i].bit_v;
  end
endmodule

// File: src/rational_arithmetic_unit_core.sv
// Top level: rational add/sub/mul/div/compare with gcd reduction.
// One item at a time. After the accepting edge an item passes through the
// cross products, the signed sum, a binary gcd (shift and subtract; its
// length depends on the operand bits), two restoring divisions by the gcd
// that run together, one quotient bit per cycle through a chain of 33 cells,
// and a final step that formats the result. An unknown action skips the
// datapath after StMul and goes straight to StOut with its result.
// Results sit in an output register; in_stall_o stays high while an item is
// in work or waiting, and the next beat is taken only once the unit is back
// in StIdle, which it enters when the result leaves.
module rational_arithmetic_unit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic signed [15:0]            left_num_i,
  input  logic signed [15:0]            left_den_i,
  input  logic signed [15:0]            right_num_i,
  input  logic signed [15:0]            right_den_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [32:0]            result_num_o,
  output logic [30:0]                   result_den_o,
  output logic [1:0]                    order_o,
  output logic                          invalid_o
);
  import rau_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StMul  = 7'b0000010,
    StSum  = 7'b0000100,
    StGcd  = 7'b0001000,
    StDiv  = 7'b0010000,
    StFin  = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  localparam int unsigned OpMag = OperandWidth + 1;
  localparam int unsigned PrW   = 2 * OperandWidth;

  state_e state_q, state_d;
  logic [2:0] act_q;
  logic [OpMag-1:0] lnm_q, ldm_q, rnm_q, rdm_q;
  logic lns_q, lds_q, rns_q, rds_q;
  logic [PrW-1:0] p0_q, p1_q, p2_q;
  logic s0_q, s1_q, s2_q;
  mag_t nmag_q, dmag_q, ga_q, gb_q;
  logic neg_q;
  logic [CntWidth-1:0] sh_q, cnt_q;
  mag_t g_q, rn_q, rd_q;
  logic bad_q;
  logic signed [32:0] onum_q;
  logic [30:0] oden_q;
  logic [1:0] ord_q;
  logic inv_q;

  function automatic logic [OpMag-1:0] absv(input logic [OperandWidth-1:0] v);
    logic [OpMag-1:0] e;
    e = {v[OperandWidth-1], v};
    return v[OperandWidth-1] ? OpMag'(-e) : e;
  endfunction

  // Division datapath: numerator and denominator divided in lockstep.
  mag_t nq, dq;
  logic clr;
  qbit_t nin, din;
  mag_t rn_sh, rd_sh;
  logic [MagWidth:0] rn_t, rd_t;
  assign rn_sh = {rn_q[MagWidth-2:0], nmag_q[MagWidth-1]};
  assign rd_sh = {rd_q[MagWidth-2:0], dmag_q[MagWidth-1]};
  assign rn_t  = {1'b0, rn_sh} - {1'b0, g_q};
  assign rd_t  = {1'b0, rd_sh} - {1'b0, g_q};
  assign nin.vld = (state_q == StDiv);
  assign nin.bit_v = !rn_t[MagWidth];
  assign din.vld = (state_q == StDiv);
  assign din.bit_v = !rd_t[MagWidth];
  assign clr = (state_q == StSum);

  rau_qchain u_nchain (.clk_i(clk_i), .rst_ni(rst_ni), .clr_i(clr), .in_i(nin), .quot_o(nq));
  rau_qchain u_dchain (.clk_i(clk_i), .rst_ni(rst_ni), .clr_i(clr), .in_i(din), .quot_o(dq));

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign result_num_o = onum_q;
  assign result_den_o = oden_q;
  assign order_o      = ord_q;
  assign invalid_o    = inv_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StMul;
      StMul:  state_d = bad_q ? StOut : StSum;
      StSum:  state_d = StGcd;
      StGcd:  if (ga_q == '0 || gb_q == '0) state_d = StDiv;
      StDiv:  if (cnt_q == CntWidth'(MagWidth - 1)) state_d = StFin;
      StFin:  state_d = StOut;
      StOut:  if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  mag_t sum_a, sum_b, gmin, gdif, gsum;
  always_comb begin
    sum_a = {1'b0, p0_q};
    sum_b = {1'b0, p1_q};
    gmin = (ga_q < gb_q) ? ga_q : gb_q;
    gdif = (ga_q < gb_q) ? (gb_q - ga_q) : (ga_q - gb_q);
    gsum = ga_q | gb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        act_q <= action_i;
        lnm_q <= absv(left_num_i);  lns_q <= left_num_i[15];
        ldm_q <= absv(left_den_i);  lds_q <= left_den_i[15];
        rnm_q <= absv(right_num_i); rns_q <= right_num_i[15];
        rdm_q <= absv(right_den_i); rds_q <= right_den_i[15];
        bad_q <= (action_i > 3'(ActCmp));
      end
      StMul: begin
        unique case (act_q)
          3'(ActMul): begin
            p0_q <= PrW'(lnm_q * rnm_q); s0_q <= lns_q ^ rns_q;
            p1_q <= '0; s1_q <= 1'b0;
            p2_q <= PrW'(ldm_q * rdm_q); s2_q <= lds_q ^ rds_q;
          end
          3'(ActDiv): begin
            p0_q <= PrW'(lnm_q * rdm_q); s0_q <= lns_q ^ rds_q;
            p1_q <= '0; s1_q <= 1'b0;
            p2_q <= PrW'(ldm_q * rnm_q); s2_q <= lds_q ^ rns_q;
          end
          3'(ActAdd): begin
            p0_q <= PrW'(lnm_q * rdm_q); s0_q <= lns_q ^ rds_q;
            p1_q <= PrW'(ldm_q * rnm_q); s1_q <= lds_q ^ rns_q;
            p2_q <= PrW'(ldm_q * rdm_q); s2_q <= lds_q ^ rds_q;
          end
          default: begin
            p0_q <= PrW'(lnm_q * rdm_q); s0_q <= lns_q ^ rds_q;
            p1_q <= PrW'(ldm_q * rnm_q); s1_q <= !(lds_q ^ rns_q);
            p2_q <= PrW'(ldm_q * rdm_q); s2_q <= lds_q ^ rds_q;
          end
        endcase
        onum_q <= '0; oden_q <= '0; ord_q <= 2'(OrdLess); inv_q <= 1'b1;
      end
      StSum: begin
        logic ns;
        mag_t nm;
        logic ps0, ps1;
        ps0 = s0_q && (p0_q != '0);
        ps1 = s1_q && (p1_q != '0);
        if (ps0 == ps1) begin
          nm = sum_a + sum_b; ns = ps0;
        end else if (sum_a >= sum_b) begin
          nm = sum_a - sum_b; ns = ps0;
        end else begin
          nm = sum_b - sum_a; ns = ps1;
        end
        nmag_q <= nm; ga_q <= nm;
        dmag_q <= {1'b0, p2_q}; gb_q <= {1'b0, p2_q};
        neg_q <= (ns && nm != '0) != (s2_q && p2_q != '0);
        sh_q <= '0;
        cnt_q <= '0;
        rn_q <= '0; rd_q <= '0;
      end
      StGcd: begin
        if (ga_q == '0 || gb_q == '0) begin
          g_q <= gsum << sh_q;
        end else if (!ga_q[0] && !gb_q[0]) begin
          ga_q <= ga_q >> 1; gb_q <= gb_q >> 1; sh_q <= sh_q + 1'b1;
        end else if (!ga_q[0]) begin
          ga_q <= ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_q <= gb_q >> 1;
        end else begin
          ga_q <= gmin; gb_q <= gdif >> 1;
        end
      end
      StDiv: begin
        rn_q <= rn_t[MagWidth] ? rn_sh : rn_t[MagWidth-1:0];
        rd_q <= rd_t[MagWidth] ? rd_sh : rd_t[MagWidth-1:0];
        nmag_q <= nmag_q << 1;
        dmag_q <= dmag_q << 1;
        cnt_q <= cnt_q + 1'b1;
      end
      StFin: begin
        logic [MagWidth-1:0] n, d;
        n = (g_q == '0) ? '0 : nq;
        d = (g_q == '0) ? '0 : dq;
        onum_q <= neg_q ? 33'(-n) : 33'(n);
        oden_q <= d[30:0];
        inv_q <= (d == '0);
        if (act_q == 3'(ActCmp)) begin
          ord_q <= (n == '0) ? 2'(OrdEqual) : (neg_q ? 2'(OrdLess) : 2'(OrdGreater));
        end else begin
          ord_q <= 2'(OrdLess);
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// File: tb/tb_rational_arithmetic_unit_core.sv
// Testbench for rational_arithmetic_unit_core: random and corner fraction beats checked against a predictor.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit_core;
  import rau_pkg::*;

  typedef struct {
    logic [2:0]         action;
    logic signed [15:0] lnum, lden, rnum, rden;
  } frac_op_t;

  typedef struct {
    logic signed [32:0] num;
    logic [30:0]        den;
    logic [1:0]         ord;
    logic               inv;
  } frac_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] action_i = '0;
  logic signed [15:0] left_num_i = '0, left_den_i = '0, right_num_i = '0, right_den_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [32:0] result_num_o;
  logic [30:0] result_den_o;
  logic [1:0] order_o;
  logic invalid_o;

  rational_arithmetic_unit_core dut (.*);

  frac_op_t  pending_ops[$];
  frac_res_t expected_results[$];
  int mismatches = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_recv = 0;
  bit done = 0;
  int quiet_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // signed magnitude helpers on 64-bit magnitudes
  function automatic longint unsigned gcd_mag(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_res_t reduce_fraction(frac_op_t op);
    frac_res_t r;
    longint signed ln, ld, rn, rd, n, d;
    longint unsigned nm, dm, g;
    bit neg;
    ln = op.lnum; ld = op.lden; rn = op.rnum; rd = op.rden;
    r.ord = OrdLess;
    case (op.action)
      ActAdd: begin n = ln * rd + ld * rn; d = ld * rd; end
      ActSub, ActCmp: begin n = ln * rd - ld * rn; d = ld * rd; end
      ActMul: begin n = ln * rn; d = ld * rd; end
      ActDiv: begin n = ln * rd; d = ld * rn; end
      default: begin
        r.num = '0; r.den = '0; r.inv = 1'b1;
        return r;
      end
    endcase
    neg = (n < 0) != (d < 0);
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    if (nm == 0) neg = (d < 0);
    g = gcd_mag(nm, dm);
    if (g == 0) begin
      nm = 0; dm = 0;
    end else begin
      nm = nm / g; dm = dm / g;
    end
    r.num = neg ? 33'(-nm) : 33'(nm);
    r.den = 31'(dm);
    r.inv = (dm == 0);
    if (op.action == ActCmp)
      r.ord = (nm == 0) ? OrdEqual : (neg ? OrdLess : OrdGreater);
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          frac_op_t op;
          op = pending_ops.pop_front();
          in_valid_i  <= 1'b1;
          action_i    <= op.action;
          left_num_i  <= op.lnum;
          left_den_i  <= op.lden;
          right_num_i <= op.rnum;
          right_den_i <= op.rden;
          expected_results.push_back(reduce_fraction(op));
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat num=%0d", result_num_o);
        end else begin
          frac_res_t e;
          e = expected_results.pop_front();
          if (e.num !== result_num_o || e.den !== result_den_o || e.ord !== order_o ||
              e.inv !== invalid_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0d/%0d ord %0d inv %0d got %0d/%0d ord %0d inv %0d",
                       e.num, e.den, e.ord, e.inv, result_num_o, result_den_o, order_o,
                       invalid_o);
          end
        end
      end
      if (quiet_cycles > 20000) begin
        $display("FAIL rational_arithmetic_unit_core");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] pick_operand();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(8)) - 4);
      3: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_op(logic [2:0] a, logic signed [15:0] ln, logic signed [15:0] ld,
                          logic signed [15:0] rn, logic signed [15:0] rd);
    frac_op_t op;
    op.action = a; op.lnum = ln; op.lden = ld; op.rnum = rn; op.rden = rd;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int a = 0; a < 8; a++) begin
      queue_op(3'(a), 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      queue_op(3'(a), 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    end
    queue_op(ActAdd, 16'sd1, 16'sd0, 16'sd1, 16'sd3);
    queue_op(ActCmp, -16'sd1, 16'sd0, 16'sd2, 16'sd5);
    queue_op(ActCmp, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
    queue_op(ActDiv, 16'sd3, 16'sd4, 16'sd0, 16'sd5);
    queue_op(ActMul, -16'sd6, 16'sd4, 16'sd9, -16'sd3);
    queue_op(ActSub, 16'sh8000, -16'sd1, 16'sh8000, 16'sd1);
    queue_op(ActCmp, 16'shffff, 16'shffff, 16'sh0001, 16'sh0001);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 8 : 0;
      if (ph == 2) hold_recv = 1;
      for (int i = 0; i < 230; i++)
        queue_op(($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4)),
                 pick_operand(), pick_operand(), pick_operand(), pick_operand());
      if (ph == 2) begin
        repeat (600) @(posedge clk_i);
        hold_recv = 0;
      end
      wait_drained();
    end
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS rational_arithmetic_unit_core");
    else
      $display("FAIL rational_arithmetic_unit_core");
    $finish;
  end
endmodule
